// File: hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the thermal supervisor sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int unsigned POLL_PERIOD_DEF = 5;

   localparam logic [1:0]  LEVEL_MAX  = 2'd3;
   localparam logic [2:0]  FAIL_LIMIT = 3'd5;

   localparam logic [15:0] TEMP_RESET      = 16'd240;
   localparam logic [15:0] WARN_HIGH_RESET = 16'd750;
   localparam logic [15:0] WARN_LOW_RESET  = 16'd230;
   localparam logic [15:0] OVERHEAT_RESET  = 16'd500;

   localparam logic [7:0]  RELAY_HEAT = 8'h10;
   localparam logic [7:0]  RELAY_COOL = 8'h04;

   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_SET_HEAT  = 3'd1,
      ACT_SET_COOL  = 3'd2,
      ACT_SAFE_ON   = 3'd3,
      ACT_SAFE_OFF  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_WARN_HIGH = 2'd0,
      CSR_WARN_LOW  = 2'd1,
      CSR_OVERHEAT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        reading_ok;
      logic [15:0] reading;
      logic [7:0]  level_value;
   } tss_req_type;

   typedef struct packed {
      logic        relay_write;
      logic [7:0]  relay_bits;
      logic        poll_done;
      logic [15:0] temperature_out;
      logic        warn_write;
      logic        warn_on;
      logic        breath_on;
      logic [2:0]  failure_count;
      logic [1:0]  heat_level_out;
      logic [1:0]  cool_level_out;
   } tss_rsp_type;

   typedef struct packed {
      logic        we;
      logic [1:0]  index;
      logic [15:0] wdata;
   } tss_csr_type;

endpackage

// File: hw/rtl/tss_in_stage.sv
// ----------------------------------------------------------------------------
// tss_in_stage
// Input register: captures one request transfer and holds it until the
// core consumes it.
// ----------------------------------------------------------------------------
module tss_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tss_pkg::tss_req_type req_data,
   input  logic                 fire,
   output logic                 item_valid,
   output tss_pkg::tss_req_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   tss_pkg::tss_req_type data_ff;

   assign req_ready  = !valid_ff || fire;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !fire);
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// File: hw/rtl/tss_core.sv
// ----------------------------------------------------------------------------
// tss_core
// Supervisor state, configuration registers and the single-pass update
// that turns one item into one result.
// ----------------------------------------------------------------------------
module tss_core #(
   parameter int unsigned POLL_PERIOD = tss_pkg::POLL_PERIOD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::tss_csr_type csr,
   input  logic                 fire,
   input  tss_pkg::tss_req_type item,
   output tss_pkg::tss_rsp_type result
);

   localparam int unsigned PHASE_W = $clog2(POLL_PERIOD + 1);
   localparam logic [PHASE_W-1:0] PHASE_POLL  = PHASE_W'(POLL_PERIOD);
   localparam logic [PHASE_W-1:0] PHASE_RELAY = PHASE_W'(1);

   logic [15:0]        warn_high_ff, warn_low_ff, overheat_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [15:0]        temp_ff, temp_in;
   logic [2:0]         fail_ff, fail_in;
   logic               blink_ff, blink_in;
   logic               warn_act_ff, warn_act_in;
   logic               breath_ff, breath_in;
   logic               latch_ff, latch_in;
   logic [1:0]         heat_ff, heat_in;
   logic [1:0]         cool_ff, cool_in;
   logic [1:0]         saved_heat_ff, saved_heat_in;
   logic [1:0]         saved_cool_ff, saved_cool_in;
   logic [7:0]         relay_ff, relay_in;

   logic [1:0]         level_clamped;
   logic [7:0]         relay_pattern;
   logic               latch_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_high_ff <= tss_pkg::WARN_HIGH_RESET;
         warn_low_ff  <= tss_pkg::WARN_LOW_RESET;
         overheat_ff  <= tss_pkg::OVERHEAT_RESET;
      end else if (csr.we) begin
         unique case (csr.index)
            tss_pkg::CSR_WARN_HIGH: warn_high_ff <= csr.wdata;
            tss_pkg::CSR_WARN_LOW:  warn_low_ff  <= csr.wdata;
            tss_pkg::CSR_OVERHEAT:  overheat_ff  <= csr.wdata;
            default: ;
         endcase
      end
   end

   assign level_clamped = (item.level_value < 8'(tss_pkg::LEVEL_MAX)) ?
                          item.level_value[1:0] : tss_pkg::LEVEL_MAX;
   assign relay_pattern = ((heat_ff != 2'd0) ? tss_pkg::RELAY_HEAT : 8'h00) |
                          ((cool_ff != 2'd0) ? tss_pkg::RELAY_COOL : 8'h00);

   always_comb begin
      phase_in      = phase_ff;
      temp_in       = temp_ff;
      fail_in       = fail_ff;
      blink_in      = blink_ff;
      warn_act_in   = warn_act_ff;
      breath_in     = breath_ff;
      latch_in      = latch_ff;
      heat_in       = heat_ff;
      cool_in       = cool_ff;
      saved_heat_in = saved_heat_ff;
      saved_cool_in = saved_cool_ff;
      relay_in      = relay_ff;
      latch_mid     = latch_ff;

      result            = '0;

      unique case (item.action)
         tss_pkg::ACT_TICK: begin
            if (phase_ff == PHASE_POLL) begin
               phase_in         = '0;
               result.poll_done = 1'b1;
               if (item.reading_ok && item.reading != 16'd0) begin
                  temp_in = item.reading;
                  fail_in = 3'd0;
               end else if (fail_ff < tss_pkg::FAIL_LIMIT) begin
                  fail_in = fail_ff + 3'd1;
               end
               if (temp_in > warn_high_ff || temp_in < warn_low_ff) begin
                  result.warn_write = 1'b1;
                  result.warn_on    = blink_ff;
                  blink_in          = !blink_ff;
                  warn_act_in       = 1'b1;
               end else if (warn_act_ff) begin
                  result.warn_write = 1'b1;
                  warn_act_in       = 1'b0;
               end
               result.breath_on = breath_ff;
               breath_in        = !breath_ff;
               if (temp_in >= overheat_ff) begin
                  cool_in   = tss_pkg::LEVEL_MAX;
                  latch_mid = 1'b1;
               end
               latch_in = latch_mid;
               if (latch_mid && temp_in <= warn_high_ff) begin
                  latch_in = 1'b0;
                  cool_in  = 2'd0;
               end
            end else begin
               if (phase_ff == PHASE_RELAY && relay_pattern != relay_ff) begin
                  relay_in           = relay_pattern;
                  result.relay_write = 1'b1;
               end
               phase_in = phase_ff + PHASE_W'(1);
            end
         end
         tss_pkg::ACT_SET_HEAT: heat_in = level_clamped;
         tss_pkg::ACT_SET_COOL: cool_in = level_clamped;
         tss_pkg::ACT_SAFE_ON: begin
            saved_heat_in = heat_ff;
            saved_cool_in = cool_ff;
            heat_in       = 2'd0;
            cool_in       = 2'd0;
         end
         tss_pkg::ACT_SAFE_OFF: begin
            heat_in = saved_heat_ff;
            cool_in = saved_cool_ff;
         end
         default: ;
      endcase

      result.relay_bits      = relay_in;
      result.temperature_out = temp_in;
      result.failure_count   = fail_in;
      result.heat_level_out  = heat_in;
      result.cool_level_out  = cool_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         temp_ff       <= tss_pkg::TEMP_RESET;
         fail_ff       <= 3'd0;
         blink_ff      <= 1'b1;
         warn_act_ff   <= 1'b0;
         breath_ff     <= 1'b1;
         latch_ff      <= 1'b0;
         heat_ff       <= 2'd0;
         cool_ff       <= 2'd0;
         saved_heat_ff <= 2'd0;
         saved_cool_ff <= 2'd0;
         relay_ff      <= 8'h00;
      end else if (fire) begin
         phase_ff      <= phase_in;
         temp_ff       <= temp_in;
         fail_ff       <= fail_in;
         blink_ff      <= blink_in;
         warn_act_ff   <= warn_act_in;
         breath_ff     <= breath_in;
         latch_ff      <= latch_in;
         heat_ff       <= heat_in;
         cool_ff       <= cool_in;
         saved_heat_ff <= saved_heat_in;
         saved_cool_ff <= saved_cool_in;
         relay_ff      <= relay_in;
      end
   end

endmodule

// File: hw/rtl/tss_out_stage.sv
// ----------------------------------------------------------------------------
// tss_out_stage
// Result register: holds one result until the response transfer.
// ----------------------------------------------------------------------------
module tss_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tss_pkg::tss_rsp_type result,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tss_pkg::tss_rsp_type rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   tss_pkg::tss_rsp_type data_ff;

   assign out_ready = !valid_ff || rsp_ready;
   assign valid_in  = fire || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

endmodule

// File: hw/rtl/thermal_supervisor_sequencer.sv
// ----------------------------------------------------------------------------
// thermal_supervisor_sequencer
// Tick-driven thermal supervisor: relay updates, sensor polling, warning and
// over-temperature handling, one result per request.
// A request passes the input register, then the result register, before
// rsp_valid rises. Throughput: one item per cycle; a result held by a low
// rsp_ready stalls the input register.
// Reset returns all supervisor state to its reset values and loads the default thresholds.
// ----------------------------------------------------------------------------
module thermal_supervisor_sequencer #(
   parameter int unsigned POLL_PERIOD = tss_pkg::POLL_PERIOD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tss_pkg::tss_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tss_pkg::tss_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   logic                 item_valid;
   logic                 out_ready;
   logic                 fire;
   tss_pkg::tss_req_type item;
   tss_pkg::tss_rsp_type result;
   tss_pkg::tss_csr_type csr;

   assign fire      = item_valid && out_ready;
   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   tss_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   tss_core #(
      .POLL_PERIOD (POLL_PERIOD)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   tss_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_fail_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.failure_count <= tss_pkg::FAIL_LIMIT)
      else $error("failure count above limit");

   a_warn_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.warn_on) |-> rsp_data.warn_write)
      else $error("warn value without warn write");

   a_relay_poll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.relay_write && rsp_data.poll_done))
      else $error("relay write and poll on the same item");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !fire) |=> (item_valid && $stable(item)))
      else $error("stalled item lost");

endmodule

// File: test/tss_status_checker.sv
// ----------------------------------------------------------------------------
// tss_status_checker
// Watches the request, response and register ports of the thermal supervisor
// sequencer, predicts the status word of every accepted request from its own
// model of the tick phases, sensor polling, warning and over-temperature
// handling, and compares each response transfer field by field.
// ----------------------------------------------------------------------------
module tss_status_checker
   import tss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  tss_req_type        req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  tss_rsp_type        rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int unsigned        fail_count,
   output int unsigned        pending,
   output int unsigned        responses,
   output int unsigned        polls
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] warn_high_lim;
   logic [15:0] warn_low_lim;
   logic [15:0] overheat_lim;

   logic [2:0]  phase;
   logic [15:0] temp;
   logic [2:0]  fails;
   logic        blink;
   logic        warn_active;
   logic        breath;
   logic        overheat;
   logic [1:0]  heat;
   logic [1:0]  cool;
   logic [1:0]  saved_heat;
   logic [1:0]  saved_cool;
   logic [7:0]  relay_last;

   tss_rsp_type predicted_status[$];

   function automatic tss_rsp_type advance_supervisor(input tss_req_type item);
      tss_rsp_type r;
      logic [15:0] t;
      logic [7:0]  bits;
      r = '0;
      case (item.action)
         ACT_TICK: begin
            if (phase == 3'(POLL_PERIOD_DEF)) begin
               phase = '0;
               r.poll_done = 1'b1;
               if (item.reading_ok && item.reading != 16'd0) begin
                  temp  = item.reading;
                  fails = '0;
               end else if (fails < FAIL_LIMIT) begin
                  fails = fails + 3'd1;
               end
               t = temp;
               if (t > warn_high_lim || t < warn_low_lim) begin
                  r.warn_write = 1'b1;
                  r.warn_on    = blink;
                  blink        = ~blink;
                  warn_active  = 1'b1;
               end else if (warn_active) begin
                  r.warn_write = 1'b1;
                  r.warn_on    = 1'b0;
                  warn_active  = 1'b0;
               end
               r.breath_on = breath;
               breath      = ~breath;
               if (t >= overheat_lim) begin
                  cool     = LEVEL_MAX;
                  overheat = 1'b1;
               end
               if (overheat && t <= warn_high_lim) begin
                  overheat = 1'b0;
                  cool     = '0;
               end
            end else begin
               if (phase == 3'd1) begin
                  bits = (heat != 2'd0 ? RELAY_HEAT : 8'h00) |
                         (cool != 2'd0 ? RELAY_COOL : 8'h00);
                  if (bits != relay_last) begin
                     relay_last    = bits;
                     r.relay_write = 1'b1;
                  end
               end
               phase = phase + 3'd1;
            end
         end
         ACT_SET_HEAT: begin
            heat = (item.level_value < LEVEL_MAX) ? item.level_value[1:0] : LEVEL_MAX;
         end
         ACT_SET_COOL: begin
            cool = (item.level_value < LEVEL_MAX) ? item.level_value[1:0] : LEVEL_MAX;
         end
         ACT_SAFE_ON: begin
            saved_heat = heat;
            saved_cool = cool;
            heat       = '0;
            cool       = '0;
         end
         ACT_SAFE_OFF: begin
            heat = saved_heat;
            cool = saved_cool;
         end
         default: begin
         end
      endcase
      r.relay_bits      = relay_last;
      r.temperature_out = temp;
      r.failure_count   = fails;
      r.heat_level_out  = heat;
      r.cool_level_out  = cool;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tss_rsp_type want;
      if (reset) begin
         warn_high_lim = WARN_HIGH_RESET;
         warn_low_lim  = WARN_LOW_RESET;
         overheat_lim  = OVERHEAT_RESET;
         phase         = '0;
         temp          = TEMP_RESET;
         fails         = '0;
         blink         = 1'b1;
         warn_active   = 1'b0;
         breath        = 1'b1;
         overheat      = 1'b0;
         heat          = '0;
         cool          = '0;
         saved_heat    = '0;
         saved_cool    = '0;
         relay_last    = '0;
         fail_count    = 0;
         responses     = 0;
         polls         = 0;
         predicted_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WARN_HIGH: warn_high_lim = csr_wdata;
               CSR_WARN_LOW:  warn_low_lim  = csr_wdata;
               CSR_OVERHEAT:  overheat_lim  = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_status.push_back(advance_supervisor(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (predicted_status.size() == 0) begin
               $error("response transfer with no prediction waiting");
               fail_count++;
            end else begin
               want = predicted_status.pop_front();
               if (want.poll_done) polls++;
               check_field("relay_write", 16'(want.relay_write),
                           16'(rsp_data.relay_write));
               check_field("relay_bits", 16'(want.relay_bits),
                           16'(rsp_data.relay_bits));
               check_field("poll_done", 16'(want.poll_done), 16'(rsp_data.poll_done));
               check_field("temperature_out", want.temperature_out,
                           rsp_data.temperature_out);
               check_field("warn_write", 16'(want.warn_write),
                           16'(rsp_data.warn_write));
               check_field("warn_on", 16'(want.warn_on), 16'(rsp_data.warn_on));
               check_field("breath_on", 16'(want.breath_on), 16'(rsp_data.breath_on));
               check_field("failure_count", 16'(want.failure_count),
                           16'(rsp_data.failure_count));
               check_field("heat_level_out", 16'(want.heat_level_out),
                           16'(rsp_data.heat_level_out));
               check_field("cool_level_out", 16'(want.cool_level_out),
                           16'(rsp_data.cool_level_out));
            end
         end
      end
      pending <= predicted_status.size();
   end

endmodule

// File: test/thermal_supervisor_sequencer_tb.sv
// ----------------------------------------------------------------------------
// thermal_supervisor_sequencer_tb
// Drives ticks and level commands into the thermal supervisor sequencer under
// a series of warning and over-temperature threshold settings, with random
// request gaps and response stalls in all but the last setting; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module thermal_supervisor_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tss_pkg::*;

   localparam int unsigned IDLE_LIMIT        = 3000;
   localparam int unsigned SETTINGS_COUNT    = 8;
   localparam int unsigned ITEMS_PER_SETTING = 250;
   localparam int unsigned DRAIN_CYCLES      = 4;
   localparam logic [2:0]  ACT_UNUSED        = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tss_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tss_rsp_type rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        steady;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned responses;
   int unsigned polls;
   int unsigned idle_cycles = 0;

   logic [15:0] lim_high;
   logic [15:0] lim_low;
   logic [15:0] lim_over;

   always #6 clock = ~clock;

   thermal_supervisor_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tss_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .responses  (responses),
      .polls      (polls)
   );

   function automatic logic [15:0] pick_reading();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'd0;
         1: v = 16'hFFFF;
         2: v = lim_low + 16'($urandom_range(0, 4)) - 16'd2;
         3: v = lim_high + 16'($urandom_range(0, 4)) - 16'd2;
         4: v = lim_over + 16'($urandom_range(0, 4)) - 16'd2;
         5, 6: v = 16'($urandom_range(lim_low, lim_high));
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_item(input tss_req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!steady && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_poll(input logic ok, input logic [15:0] reading);
      for (int i = 0; i < 5; i++) begin
         send_item(tss_req_type'{action: ACT_TICK, reading_ok: 1'($urandom),
                                 reading: 16'($urandom), level_value: 8'($urandom)});
      end
      send_item(tss_req_type'{action: ACT_TICK, reading_ok: ok, reading: reading,
                              level_value: 8'($urandom)});
   endtask

   initial begin : rsp_pacing
      int unsigned span;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!steady && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
         end else begin
            span = $urandom_range(1, 24);
            rsp_ready <= 1'b1;
         end
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      tss_req_type item;
      int unsigned pick;
      logic [15:0] h;
      logic [15:0] l;
      logic [15:0] o;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_WARN_HIGH;
      csr_wdata = '0;
      steady    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < SETTINGS_COUNT; p++) begin
         case (p)
            0, 7: begin
               h = WARN_HIGH_RESET; l = WARN_LOW_RESET; o = OVERHEAT_RESET;
            end
            2: begin
               h = 16'd0; l = 16'd0; o = 16'd0;
            end
            3: begin
               h = 16'hFFFF; l = 16'hFFFF; o = 16'hFFFF;
            end
            4: begin
               h = 16'd0; l = 16'hFFFF; o = 16'hFFFF;
            end
            5: begin
               h = 16'hFFFF; l = 16'd0; o = 16'd0;
            end
            6: begin
               l = 16'($urandom_range(0, 1000));
               h = 16'($urandom_range(l, 2000));
               o = 16'($urandom_range(l, h + 200));
            end
            default: begin
               h = 16'($urandom); l = 16'($urandom); o = 16'($urandom);
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= CSR_WARN_HIGH;
         csr_wdata <= h;
         @(posedge clock);
         csr_index <= CSR_WARN_LOW;
         csr_wdata <= l;
         @(posedge clock);
         csr_index <= CSR_OVERHEAT;
         csr_wdata <= o;
         @(posedge clock);
         csr_we   <= 1'b0;
         lim_high = h;
         lim_low  = l;
         lim_over = o;

         if (p == 0) begin
            send_item(tss_req_type'{action: ACT_SET_HEAT, reading_ok: 1'b0,
                                    reading: 16'd0, level_value: 8'hFF});
            send_item(tss_req_type'{action: ACT_SET_COOL, reading_ok: 1'b1,
                                    reading: 16'hFFFF, level_value: 8'd2});
            send_item(tss_req_type'{action: ACT_SAFE_ON, reading_ok: 1'b0,
                                    reading: 16'd0, level_value: 8'd0});
            run_poll(1'b0, 16'hFFFF);
            send_item(tss_req_type'{action: ACT_SAFE_OFF, reading_ok: 1'b1,
                                    reading: 16'd1, level_value: 8'd1});
            run_poll(1'b1, 16'hFFFF);
            send_item(tss_req_type'{action: ACT_UNUSED, reading_ok: 1'b1,
                                    reading: 16'hFFFF, level_value: 8'hFF});
            send_item(tss_req_type'{action: ACT_SET_COOL, reading_ok: 1'b0,
                                    reading: 16'd0, level_value: 8'd0});
            run_poll(1'b1, 16'd600);
         end
         if (p == SETTINGS_COUNT - 1) steady <= 1'b1;

         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            item.reading_ok  = ($urandom_range(0, 5) != 0);
            item.reading     = pick_reading();
            item.level_value = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 4));
            pick = $urandom_range(0, 99);
            if (pick < 64)      item.action = ACT_TICK;
            else if (pick < 73) item.action = ACT_SET_HEAT;
            else if (pick < 82) item.action = ACT_SET_COOL;
            else if (pick < 88) item.action = ACT_SAFE_ON;
            else if (pick < 94) item.action = ACT_SAFE_OFF;
            else item.action = 3'($urandom_range(ACT_SAFE_OFF + 1, ACT_UNUSED));
            send_item(item);
         end
         req_valid <= 1'b0;
         do @(posedge clock); while (pending != 0);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d status responses, %0d of them sensor polls,", responses, polls);
      $display("across %0d warning and over-temperature threshold settings", SETTINGS_COUNT);
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
